// ----- sv/ir_edge_pulse_space_recorder_top_assert.svh -----
// assertion macros for the edge pulse space recorder
`ifndef IR_EDGE_PULSE_SPACE_RECORDER_TOP_ASSERT_SVH
`define IR_EDGE_PULSE_SPACE_RECORDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EPSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define EPSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EPSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define EPSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/epsr_pkg.sv -----
`default_nettype none
package epsr_pkg;
   localparam int DURATION_BITS_DEF = 24;
   localparam int LIMIT_BITS = 24;
   localparam int GAP_BITS = 8;
   localparam int SEC_BITS = 32;
   localparam int USEC_BITS = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam logic [USEC_BITS-1:0] USEC_PER_SEC = 20'd1000000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LOW = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSE_NOISE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_SPACE_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_GAP_SECONDS = 2'd3;

   localparam logic [LIMIT_BITS-1:0] PULSE_NOISE_LIMIT_RST = 24'd250;
   localparam logic [LIMIT_BITS-1:0] LONG_SPACE_LIMIT_RST = 24'd20000;
   localparam logic [GAP_BITS-1:0] LONG_GAP_SECONDS_RST = 8'd15;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic active_low;
      logic [LIMIT_BITS-1:0] pulse_noise_limit;
      logic [LIMIT_BITS-1:0] long_space_limit;
      logic [GAP_BITS-1:0] long_gap_seconds;
   } cfg_type;
endpackage
`default_nettype wire

// ----- sv/epsr_ifs.sv -----
`default_nettype none
interface epsr_req_if import epsr_pkg::*; ();
   logic valid;
   logic ready;
   logic op;
   logic level;
   logic [SEC_BITS-1:0] now_seconds;
   logic [USEC_BITS-1:0] now_microseconds;
   modport source (output valid, op, level, now_seconds, now_microseconds, input ready);
   modport sink (input valid, op, level, now_seconds, now_microseconds, output ready);
endinterface

interface epsr_rsp_if import epsr_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) ();
   logic valid;
   logic ready;
   logic is_pulse;
   logic [DURATION_BITS-1:0] duration;
   logic last_of_run;
   modport source (output valid, is_pulse, duration, last_of_run, input ready);
   modport sink (input valid, is_pulse, duration, last_of_run, output ready);
endinterface

interface epsr_csr_if import epsr_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/epsr_gap.sv -----
`default_nettype none
module epsr_gap import epsr_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   epsr_req_if.sink req_if,
   input wire cfg_type cfg,
   output logic mark_valid,
   input wire logic mark_ready,
   output logic mark_pulse,
   output logic [DURATION_BITS-1:0] mark_dur
);
   localparam logic [31:0] FULL32 = 32'((64'd1 << DURATION_BITS) - 64'd1);
   localparam logic [DURATION_BITS-1:0] FULL = FULL32[DURATION_BITS-1:0];

   logic in_valid_ff;
   logic op_ff;
   logic level_ff;
   logic [SEC_BITS-1:0] sec_ff;
   logic [USEC_BITS-1:0] usec_ff;

   logic [SEC_BITS-1:0] prev_sec_ff;
   logic [USEC_BITS-1:0] prev_usec_ff;
   logic flipped_ff, flipped_in;

   logic mark_valid_ff;
   logic mark_pulse_ff, mark_pulse_in;
   logic [DURATION_BITS-1:0] mark_dur_ff, mark_dur_in;

   logic mark_free;
   logic step;
   logic [SEC_BITS-1:0] sec_diff;
   logic backwards;
   logic long_gap;
   logic sense;
   logic [31:0] pos;
   logic [31:0] diff;

   assign mark_free = !mark_valid_ff || mark_ready;
   assign step = in_valid_ff && (op_ff == OP_START || mark_free);
   assign req_if.ready = !in_valid_ff || step;

   // gap since the previous stamp
   always_comb begin
      sec_diff = sec_ff - prev_sec_ff;
      backwards = (sec_ff < prev_sec_ff) || (sec_ff == prev_sec_ff && usec_ff < prev_usec_ff);
      long_gap = sec_diff > 32'(cfg.long_gap_seconds);
      pos = 32'(sec_diff[GAP_BITS-1:0]) * 32'(USEC_PER_SEC) + 32'(usec_ff);
      diff = pos - 32'(prev_usec_ff);
      sense = cfg.active_low ^ flipped_ff;
      flipped_in = flipped_ff;
      if (backwards) begin
         mark_dur_in = FULL;
      end else if (long_gap) begin
         mark_dur_in = FULL;
         if (level_ff == sense) begin
            flipped_in = !flipped_ff;
            sense = !sense;
         end
      end else if (pos < 32'(prev_usec_ff)) begin
         mark_dur_in = '0;
      end else if (diff > FULL32) begin
         mark_dur_in = FULL;
      end else begin
         mark_dur_in = diff[DURATION_BITS-1:0];
      end
      mark_pulse_in = level_ff == sense;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mark_valid_ff <= 1'b0;
         prev_sec_ff <= '0;
         prev_usec_ff <= '0;
         flipped_ff <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            prev_sec_ff <= sec_ff;
            prev_usec_ff <= usec_ff;
            if (op_ff == OP_EDGE) begin
               flipped_ff <= flipped_in;
            end
         end
         if (step && op_ff == OP_EDGE) begin
            mark_valid_ff <= 1'b1;
         end else if (mark_ready) begin
            mark_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         op_ff <= req_if.op;
         level_ff <= req_if.level;
         sec_ff <= req_if.now_seconds;
         usec_ff <= req_if.now_microseconds;
      end
      if (step && op_ff == OP_EDGE) begin
         mark_pulse_ff <= mark_pulse_in;
         mark_dur_ff <= mark_dur_in;
      end
   end

   assign mark_valid = mark_valid_ff;
   assign mark_pulse = mark_pulse_ff;
   assign mark_dur = mark_dur_ff;
endmodule
`default_nettype wire

// ----- sv/epsr_filter.sv -----
`default_nettype none
module epsr_filter import epsr_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire cfg_type cfg,
   input wire logic mark_valid,
   output logic mark_ready,
   input wire logic mark_pulse,
   input wire logic [DURATION_BITS-1:0] mark_dur,
   epsr_rsp_if.source rsp_if
);
   localparam logic [31:0] FULL32 = 32'((64'd1 << DURATION_BITS) - 64'd1);
   localparam logic [DURATION_BITS-1:0] FULL = FULL32[DURATION_BITS-1:0];

   function automatic logic [DURATION_BITS-1:0] sat_add(
      input logic [DURATION_BITS-1:0] a,
      input logic [DURATION_BITS-1:0] b
   );
      logic [DURATION_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DURATION_BITS] ? FULL : s[DURATION_BITS-1:0];
   endfunction

   logic held_ff, held_in;
   logic [DURATION_BITS-1:0] held_len_ff, held_len_in;
   logic [DURATION_BITS-1:0] merged_ff, merged_in;

   logic [1:0] count_ff, count_in;
   logic [1:0] index_ff;
   logic word_pulse_ff [0:2];
   logic [DURATION_BITS-1:0] word_dur_ff [0:2];
   logic word_pulse_in [0:2];
   logic [DURATION_BITS-1:0] word_dur_in [0:2];

   logic take;
   logic last;
   logic out_done;
   logic [DURATION_BITS-1:0] merged_sum;
   logic [DURATION_BITS-1:0] held_sum;
   logic release_held;
   logic long_space;

   assign last = index_ff == 2'(count_ff - 2'd1);
   assign out_done = rsp_if.valid && rsp_if.ready && last;
   assign mark_ready = (count_ff == 2'd0) || out_done;
   assign take = mark_valid && mark_ready;

   always_comb begin
      merged_sum = sat_add(merged_ff, mark_dur);
      held_sum = sat_add(sat_add(held_len_ff, merged_ff), mark_dur);
      release_held = 32'(merged_sum) > 32'(cfg.pulse_noise_limit);
      long_space = 32'(mark_dur) > 32'(cfg.long_space_limit);
      held_in = held_ff;
      held_len_in = held_len_ff;
      merged_in = merged_ff;
      count_in = 2'd0;
      for (int i = 0; i < 3; i++) begin
         word_pulse_in[i] = 1'b0;
         word_dur_in[i] = mark_dur;
      end
      if (held_ff && mark_pulse) begin
         merged_in = merged_sum;
         if (release_held) begin
            word_dur_in[0] = held_len_ff;
            word_pulse_in[1] = 1'b1;
            word_dur_in[1] = merged_sum;
            count_in = 2'd2;
            held_in = 1'b0;
            merged_in = '0;
         end
      end else if (!mark_pulse) begin
         if (!held_ff) begin
            if (long_space) begin
               held_len_in = mark_dur;
               held_in = 1'b1;
            end else begin
               count_in = 2'd1;
            end
         end else if (long_space) begin
            held_len_in = held_sum;
            merged_in = '0;
         end else begin
            // release the held space and pulse, then the short space
            word_dur_in[0] = held_len_ff;
            word_pulse_in[1] = 1'b1;
            word_dur_in[1] = merged_ff;
            word_dur_in[2] = mark_dur;
            count_in = 2'd3;
            held_in = 1'b0;
            merged_in = '0;
         end
      end else begin
         word_pulse_in[0] = 1'b1;
         count_in = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         held_len_ff <= '0;
         merged_ff <= '0;
         count_ff <= 2'd0;
         index_ff <= 2'd0;
      end else begin
         if (take) begin
            held_ff <= held_in;
            held_len_ff <= held_len_in;
            merged_ff <= merged_in;
            count_ff <= count_in;
            index_ff <= 2'd0;
         end else if (out_done) begin
            count_ff <= 2'd0;
            index_ff <= 2'd0;
         end else if (rsp_if.valid && rsp_if.ready) begin
            index_ff <= index_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 3; i++) begin
            word_pulse_ff[i] <= word_pulse_in[i];
            word_dur_ff[i] <= word_dur_in[i];
         end
      end
   end

   assign rsp_if.valid = count_ff != 2'd0;
   assign rsp_if.is_pulse = word_pulse_ff[index_ff];
   assign rsp_if.duration = word_dur_ff[index_ff];
   assign rsp_if.last_of_run = last;
endmodule
`default_nettype wire

// ----- sv/ir_edge_pulse_space_recorder_top.sv -----
// ir edge pulse/space recorder
// req_if takes one receiver edge request: op, pin level and a time stamp in
// seconds and microseconds. a start request only records the stamp.
// rsp_if gives zero to three words per edge request: pulse or space mark,
// duration in microseconds saturated at full scale, and last_of_run on the
// final word of that request.
// csr_if writes one register per request and is always ready; write it only
// while the block is idle.
// the gap stage registers the request and turns it into a registered mark;
// the filter stage loads that mark into a three-word buffer, from which the
// first word is driven on rsp_if.
// throughput is one request per cycle for requests giving at most one word
// while rsp_if is ready; a request giving more words keeps the next mark out
// of the buffer until it drains, one word per cycle while rsp_if is ready.
// a stalled rsp_if holds the current word; a further edge request can still
// fill the mark register and another the gap stage input register, and any
// start requests among them are taken too, before req_if.ready drops.
// reset clears the stamp, sense, filter state and buffer count and loads the
// register defaults; nothing is pending after reset.
`default_nettype none
`include "ir_edge_pulse_space_recorder_top_assert.svh"
module ir_edge_pulse_space_recorder_top import epsr_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   epsr_req_if.sink req_if,
   epsr_rsp_if.source rsp_if,
   epsr_csr_if.sink csr_if
);
   cfg_type cfg_ff;
   logic mark_valid;
   logic mark_ready;
   logic mark_pulse;
   logic [DURATION_BITS-1:0] mark_dur;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low <= 1'b0;
         cfg_ff.pulse_noise_limit <= PULSE_NOISE_LIMIT_RST;
         cfg_ff.long_space_limit <= LONG_SPACE_LIMIT_RST;
         cfg_ff.long_gap_seconds <= LONG_GAP_SECONDS_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_ACTIVE_LOW: begin
               cfg_ff.active_low <= csr_if.data[0];
            end
            CSR_PULSE_NOISE_LIMIT: begin
               cfg_ff.pulse_noise_limit <= csr_if.data[LIMIT_BITS-1:0];
            end
            CSR_LONG_SPACE_LIMIT: begin
               cfg_ff.long_space_limit <= csr_if.data[LIMIT_BITS-1:0];
            end
            CSR_LONG_GAP_SECONDS: begin
               cfg_ff.long_gap_seconds <= csr_if.data[GAP_BITS-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   epsr_gap #(
      .DURATION_BITS(DURATION_BITS)
   ) u_gap (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .cfg(cfg_ff),
      .mark_valid(mark_valid),
      .mark_ready(mark_ready),
      .mark_pulse(mark_pulse),
      .mark_dur(mark_dur)
   );

   epsr_filter #(
      .DURATION_BITS(DURATION_BITS)
   ) u_filter (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .mark_valid(mark_valid),
      .mark_ready(mark_ready),
      .mark_pulse(mark_pulse),
      .mark_dur(mark_dur),
      .rsp_if(rsp_if)
   );

   // words of one run follow without a gap in valid
   `EPSR_ASSERT_NEXT(a_run_continues, clock, reset, rsp_if.valid && rsp_if.ready && !rsp_if.last_of_run, rsp_if.valid, "run ended before its last word")
   // a new mark is only loaded once the previous run is finished
   `EPSR_ASSERT_SAME(a_load_after_run, clock, reset, mark_valid && mark_ready, !rsp_if.valid || (rsp_if.ready && rsp_if.last_of_run), "mark loaded over a pending run")
endmodule
`default_nettype wire

// ----- tb/sv/epsr_mark_monitor.sv -----
module epsr_mark_monitor import epsr_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   epsr_req_if req,
   epsr_rsp_if rsp,
   epsr_csr_if csr,
   output int fail_count,
   output int pending_words
);

   typedef struct packed {
      logic is_pulse;
      logic [DURATION_BITS-1:0] duration;
      logic last_of_run;
   } mark_word_t;

   localparam logic [63:0] FULL_DURATION = (64'd1 << DURATION_BITS) - 64'd1;

   cfg_type cfg;
   logic [SEC_BITS-1:0] last_sec;
   logic [USEC_BITS-1:0] last_usec;
   logic flipped;
   logic holding;
   logic [63:0] held_len;
   logic [63:0] merged_len;
   int errors;
   mark_word_t expected_marks[$];

   function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
      return (a + b > FULL_DURATION) ? FULL_DURATION : a + b;
   endfunction

   function automatic void push_mark(logic pulse, logic [63:0] dur);
      mark_word_t w;
      w.is_pulse = pulse;
      w.duration = dur[DURATION_BITS-1:0];
      w.last_of_run = 1'b0;
      expected_marks.push_back(w);
   endfunction

   function automatic void record_edge(logic op, logic level, logic [SEC_BITS-1:0] s,
                                       logic [USEC_BITS-1:0] us);
      logic sense;
      logic pulse;
      logic [63:0] dur;
      logic [63:0] gap_s;
      logic [63:0] pos;
      int base;
      mark_word_t tail;
      base = expected_marks.size();
      if (op == OP_START) begin
         last_sec = s;
         last_usec = us;
         return;
      end
      sense = cfg.active_low ^ flipped;
      gap_s = 64'(s) - 64'(last_sec);
      if (s < last_sec || (s == last_sec && us < last_usec)) begin
         dur = FULL_DURATION;
      end else if (gap_s > 64'(cfg.long_gap_seconds)) begin
         dur = FULL_DURATION;
         // a long gap that looks like a pulse flips the sense
         if (level == sense) begin
            flipped = ~flipped;
            sense = ~sense;
         end
      end else begin
         pos = gap_s * 64'(USEC_PER_SEC) + 64'(us);
         if (pos < 64'(last_usec)) begin
            dur = 64'd0;
         end else begin
            dur = pos - 64'(last_usec);
            if (dur > FULL_DURATION) dur = FULL_DURATION;
         end
      end
      last_sec = s;
      last_usec = us;
      pulse = (level == sense);

      if (holding && pulse) begin
         merged_len = sum_sat(merged_len, dur);
         if (merged_len > 64'(cfg.pulse_noise_limit)) begin
            push_mark(1'b0, held_len);
            push_mark(1'b1, merged_len);
            holding = 1'b0;
            merged_len = 64'd0;
         end
      end else if (!pulse) begin
         if (!holding) begin
            if (dur > 64'(cfg.long_space_limit)) begin
               held_len = dur;
               holding = 1'b1;
            end else begin
               push_mark(1'b0, dur);
            end
         end else if (dur > 64'(cfg.long_space_limit)) begin
            held_len = sum_sat(sum_sat(held_len, merged_len), dur);
            merged_len = 64'd0;
         end else begin
            push_mark(1'b0, held_len);
            push_mark(1'b1, merged_len);
            holding = 1'b0;
            merged_len = 64'd0;
            push_mark(1'b0, dur);
         end
      end else begin
         push_mark(1'b1, dur);
      end

      if (expected_marks.size() > base) begin
         tail = expected_marks.pop_back();
         tail.last_of_run = 1'b1;
         expected_marks.push_back(tail);
      end
   endfunction

   always @(posedge clock) begin : watch
      mark_word_t want;
      if (reset) begin
         cfg.active_low = 1'b0;
         cfg.pulse_noise_limit = PULSE_NOISE_LIMIT_RST;
         cfg.long_space_limit = LONG_SPACE_LIMIT_RST;
         cfg.long_gap_seconds = LONG_GAP_SECONDS_RST;
         last_sec = '0;
         last_usec = '0;
         flipped = 1'b0;
         holding = 1'b0;
         held_len = 64'd0;
         merged_len = 64'd0;
         errors = 0;
         expected_marks.delete();
         fail_count <= 0;
         pending_words <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_ACTIVE_LOW: cfg.active_low = csr.data[0];
               CSR_PULSE_NOISE_LIMIT: cfg.pulse_noise_limit = csr.data[LIMIT_BITS-1:0];
               CSR_LONG_SPACE_LIMIT: cfg.long_space_limit = csr.data[LIMIT_BITS-1:0];
               CSR_LONG_GAP_SECONDS: cfg.long_gap_seconds = csr.data[GAP_BITS-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            record_edge(req.op, req.level, req.now_seconds, req.now_microseconds);
         if (rsp.valid && rsp.ready) begin
            if (expected_marks.size() == 0) begin
               $error("unexpected word: is_pulse %0d duration %0d last_of_run %0d",
                      rsp.is_pulse, rsp.duration, rsp.last_of_run);
               errors++;
            end else begin
               want = expected_marks.pop_front();
               if (rsp.is_pulse !== want.is_pulse) begin
                  $error("is_pulse: expected %0d actual %0d", want.is_pulse, rsp.is_pulse);
                  errors++;
               end
               if (rsp.duration !== want.duration) begin
                  $error("duration: expected %0d actual %0d", want.duration, rsp.duration);
                  errors++;
               end
               if (rsp.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d actual %0d",
                         want.last_of_run, rsp.last_of_run);
                  errors++;
               end
            end
         end
         fail_count <= errors;
         pending_words <= expected_marks.size();
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   import epsr_pkg::*;

   localparam int PHASE_ITEMS = 75;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;
   logic idling;
   logic long_hold;
   logic last_level;
   logic [SEC_BITS-1:0] stamp_sec;
   logic [USEC_BITS-1:0] stamp_usec;
   int unsigned noise_limit;
   int unsigned space_limit;
   int unsigned gap_limit;
   int fail_count;
   int pending_words;
   int quiet_cycles;

   epsr_req_if req_if ();
   epsr_rsp_if rsp_if ();
   epsr_csr_if csr_if ();

   ir_edge_pulse_space_recorder_top dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   epsr_mark_monitor mark_monitor (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if),
      .fail_count(fail_count),
      .pending_words(pending_words)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end else begin
         quiet_cycles <= 0;
      end
   end

   initial begin : result_sink
      bit hold_done;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic set_config(input logic al, input int unsigned pnl, input int unsigned lsl,
                             input int unsigned gap);
      write_reg(CSR_ACTIVE_LOW, CSR_DATA_BITS'(al));
      write_reg(CSR_PULSE_NOISE_LIMIT, CSR_DATA_BITS'(pnl));
      write_reg(CSR_LONG_SPACE_LIMIT, CSR_DATA_BITS'(lsl));
      write_reg(CSR_LONG_GAP_SECONDS, CSR_DATA_BITS'(gap));
      csr_if.valid <= 1'b0;
      noise_limit = pnl;
      space_limit = lsl;
      gap_limit = gap;
   endtask

   task automatic send_request(input logic op, input logic level, input logic [SEC_BITS-1:0] s,
                               input logic [USEC_BITS-1:0] us);
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.level <= level;
      req_if.now_seconds <= s;
      req_if.now_microseconds <= us;
      stamp_sec = s;
      stamp_usec = us;
      if (op == OP_EDGE) last_level = level;
      do @(posedge clock); while (!req_if.ready);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic longint unsigned around(int unsigned x);
      if (x > 100) return longint'(x) - 100 + $urandom_range(0, 200);
      return $urandom_range(0, x + 100);
   endfunction

   task automatic random_request();
      logic op;
      logic level;
      logic [SEC_BITS-1:0] s;
      logic [USEC_BITS-1:0] us;
      longint unsigned step;
      longint unsigned total;
      int kind;
      op = OP_EDGE;
      s = stamp_sec;
      us = stamp_usec;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         op = OP_START;
         s = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
         us = USEC_BITS'($urandom_range(0, 999999));
      end else if (kind < 10) begin
         // clock runs backwards
         if (us != 0 && $urandom_range(0, 1)) us = USEC_BITS'($urandom_range(0, us - 1));
         else s = s - $urandom_range(1, 3);
      end else if (kind < 16) begin
         // seconds jump just below, at and above the long gap limit
         s = s + gap_limit + $urandom_range(0, 2) - 1;
         us = USEC_BITS'($urandom_range(0, 999999));
      end else begin
         case ($urandom_range(0, 5))
            0, 1: step = $urandom_range(50, 900);
            2: step = around(noise_limit);
            3: step = around(space_limit);
            4: step = $urandom_range(0, 3000000);
            default: step = $urandom_range(0, 30000);
         endcase
         total = longint'(us) + step;
         s = s + SEC_BITS'(total / USEC_PER_SEC);
         us = USEC_BITS'(total % USEC_PER_SEC);
      end
      if ($urandom_range(0, 99) < 85) level = ~last_level;
      else level = 1'($urandom_range(0, 1));
      send_request(op, level, s, us);
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      idling = 1'b1;
      long_hold = 1'b0;
      last_level = 1'b0;
      stamp_sec = '0;
      stamp_usec = '0;
      req_if.valid <= 1'b0;
      req_if.op <= OP_EDGE;
      req_if.level <= 1'b0;
      req_if.now_seconds <= '0;
      req_if.now_microseconds <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_ACTIVE_LOW;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_config(1'b0, 32'(PULSE_NOISE_LIMIT_RST), 32'(LONG_SPACE_LIMIT_RST),
                 32'(LONG_GAP_SECONDS_RST));
      send_request(OP_START, 1'b0, 32'd100, 20'd0);
      send_request(OP_EDGE, 1'b0, 32'd100, 20'd500);
      send_request(OP_EDGE, 1'b1, 32'd100, 20'd1500);
      send_request(OP_EDGE, 1'b1, 32'd100, 20'd999999);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd100);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd200);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd300);
      send_request(OP_EDGE, 1'b1, 32'd101, 20'd50300);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd50400);
      send_request(OP_EDGE, 1'b1, 32'd101, 20'd90400);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd90500);
      send_request(OP_EDGE, 1'b1, 32'd101, 20'd90600);
      send_request(OP_EDGE, 1'b1, 32'd101, 20'd90000);
      send_request(OP_EDGE, 1'b0, 32'd101, 20'd90000);
      send_request(OP_EDGE, 1'b1, 32'd117, 20'd0);
      send_request(OP_EDGE, 1'b0, 32'd140, 20'd5);
      send_request(OP_EDGE, 1'b1, 32'd140, 20'd105);
      send_request(OP_EDGE, 1'b1, 32'd140, 20'd405);
      send_request(OP_EDGE, 1'b0, 32'd155, 20'd405);
      send_request(OP_EDGE, 1'b1, 32'd155, 20'd505);
      send_request(OP_START, 1'b1, 32'hFFFFFFFF, 20'd999999);
      send_request(OP_EDGE, 1'b0, 32'd0, 20'd0);
      send_request(OP_START, 1'b0, 32'd0, 20'd0);
      send_request(OP_EDGE, 1'b1, 32'd16, 20'd999999);
      req_if.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         idling = (phase != 2 && phase != 5);
         case (phase)
            0: set_config(1'b1, 250, 20000, 15);
            1: set_config(1'b0, 0, 0, 0);
            2: set_config(1'b1, 32'hFFFFFF, 32'hFFFFFF, 255);
            3: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 2000),
                          $urandom_range(0, 60000), $urandom_range(0, 20));
            4: set_config(1'($urandom_range(0, 1)), $urandom_range(0, 32'hFFFFFF),
                          $urandom_range(0, 32'hFFFFFF), $urandom_range(0, 255));
            default: set_config(1'b0, 32'(PULSE_NOISE_LIMIT_RST), 32'(LONG_SPACE_LIMIT_RST),
                                32'(LONG_GAP_SECONDS_RST));
         endcase
         // results back up while requests keep coming
         if (phase == 3) long_hold = 1'b1;
         repeat (PHASE_ITEMS) random_request();
         req_if.valid <= 1'b0;
         wait_drained();
      end

      if (fail_count == 0 && pending_words == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
